[rtl/sonar_packet_to_xy_points_defines.svh]
// ----------------------------------------------------------------------------
// Sonar packet to x/y points - assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SONAR_PACKET_TO_XY_POINTS_DEFINES_SVH
`define SONAR_PACKET_TO_XY_POINTS_DEFINES_SVH

// checked outside reset
`define SPXY_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset as well
`define SPXY_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/spxy_pkg.sv]
// ----------------------------------------------------------------------------
// Sonar packet to x/y points - package
// Types, constants and tables shared by the controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spxy_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int ZW           = 40;   // angle in Q30 degrees, signed
   localparam int XW           = 52;   // rotation datapath, signed
   localparam int OUT_W        = 41;

   localparam logic [17:0] OFFSET_MAX   = 18'h3FFFF;
   localparam logic [17:0] OFS_BEAMS_HI = 18'd70;
   localparam logic [17:0] OFS_BEAMS_LO = 18'd71;
   localparam logic [17:0] OFS_SECT_HI  = 18'd74;
   localparam logic [17:0] OFS_SECT_LO  = 18'd75;
   localparam logic [17:0] OFS_RES_HI   = 18'd85;
   localparam logic [17:0] OFS_RES_LO   = 18'd86;
   localparam logic [17:0] OFS_LAT_HI   = 18'd120;
   localparam logic [17:0] OFS_LAT_LO   = 18'd121;

   localparam logic signed [18:0] DEG360_Q8 = 19'sd92160;
   localparam logic [8:0]         DEG360    = 9'd360;

   localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

   localparam logic signed [ZW-1:0] DEG90_Q30  = 40'sd96636764160;
   localparam logic signed [ZW-1:0] DEG180_Q30 = 40'sd193273528320;
   localparam logic signed [ZW-1:0] DEG360_Q30 = 40'sd386547056640;

   localparam logic signed [XW-1:0] OUT_MAX = 52'sd1099511627775;
   localparam logic signed [XW-1:0] OUT_MIN = -52'sd1099511627776;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic mul1;
      logic mul2;
      logic rot_step;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic is_bdo;
      logic is_beam;
      logic div_last;
      logic rot_last;
      logic out_free;
   } sts_type;

   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:  v = 40'sd48318382080;
         5'd1:  v = 40'sd28524006505;
         5'd2:  v = 40'sd15071301663;
         5'd3:  v = 40'sd7650428050;
         5'd4:  v = 40'sd3840059795;
         5'd5:  v = 40'sd1921901881;
         5'd6:  v = 40'sd961185452;
         5'd7:  v = 40'sd480622057;
         5'd8:  v = 40'sd240314695;
         5'd9:  v = 40'sd120157806;
         5'd10: v = 40'sd60078960;
         5'd11: v = 40'sd30039487;
         5'd12: v = 40'sd15019745;
         5'd13: v = 40'sd7509872;
         5'd14: v = 40'sd3754936;
         5'd15: v = 40'sd1877468;
         5'd16: v = 40'sd938734;
         5'd17: v = 40'sd469367;
         5'd18: v = 40'sd234684;
         5'd19: v = 40'sd117342;
         5'd20: v = 40'sd58671;
         5'd21: v = 40'sd29335;
         5'd22: v = 40'sd14668;
         5'd23: v = 40'sd7334;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [OUT_W-1:0] sat_out(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] s;
      if (v > OUT_MAX) begin
         s = OUT_MAX;
      end else if (v < OUT_MIN) begin
         s = OUT_MIN;
      end else begin
         s = v;
      end
      return s[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/spxy_ctrl.sv]
// ----------------------------------------------------------------------------
// Sonar packet to x/y points - controller
// Sequences byte intake, angle-step division and beam rotation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spxy_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire spxy_pkg::sts_type sts,
   output spxy_pkg::cmd_type      cmd
);
   import spxy_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_MUL1 = 6'b000100,
      ST_MUL2 = 6'b001000,
      ST_ROT  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               if (sts.is_bdo) begin
                  state_in = ST_DIV;
               end else if (sts.is_beam) begin
                  state_in = ST_MUL1;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            cmd.rot_step = 1'b1;
            if (sts.rot_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/spxy_datapath.sv]
// ----------------------------------------------------------------------------
// Sonar packet to x/y points - datapath
// Header capture, restoring divider, multipliers, CORDIC and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spxy_datapath #(
   parameter int ANGLE_FRAC_BITS  = 16,
   parameter int BEAM_DATA_OFFSET = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [7:0]                    data_byte,
   input  wire logic                          packet_start,
   input  wire logic                          csr_we,
   input  wire logic [17:0]                   csr_data,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tvalid,
   output logic [spxy_pkg::OUT_W-1:0]         x_pos,
   output logic [spxy_pkg::OUT_W-1:0]         y_pos,
   output logic [15:0]                        beam_index,
   output logic [15:0]                        ping_latency,
   output logic                               last_beam,
   input  wire spxy_pkg::cmd_type             cmd,
   output spxy_pkg::sts_type                  sts
);
   import spxy_pkg::*;

   localparam int AW = 9 + ANGLE_FRAC_BITS;
   localparam int DW = 16 + ANGLE_FRAC_BITS;
   localparam int CW = $clog2(DW + 1);
   localparam logic [17:0] BDO = 18'(BEAM_DATA_OFFSET);

   logic [17:0]  start_ff;
   logic [17:0]  offset_ff;
   logic [15:0]  beams_ff, sector_ff, res_ff, lat_ff, done_ff;
   logic [7:0]   hold_ff;
   logic [AW-1:0] angle_ff, step_ff;

   logic [15:0]  range_ff;
   logic [31:0]  mag_ff;
   logic [15:0]  rem_ff, dvd_ff;
   logic [8:0]   qhi_ff;
   logic [ANGLE_FRAC_BITS-1:0] qlo_ff;
   logic [CW-1:0] iter_ff;
   logic signed [XW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;
   logic          flip_ff;
   logic          valid_ff;
   logic [OUT_W-1:0] xo_ff, yo_ff;
   logic [15:0]   idx_ff, lato_ff;
   logic          last_ff;

   logic [17:0]  cur;
   logic         at_data;
   logic         odd_rel;

   always_comb begin
      cur         = packet_start ? 18'd0 : offset_ff;
      at_data     = (cur >= BDO);
      odd_rel     = cur[0] ^ BDO[0];
      sts.is_bdo  = (cur == BDO);
      sts.is_beam = at_data && odd_rel && (done_ff < beams_ff);
      sts.div_last = (iter_ff == CW'(DW - 1));
      sts.rot_last = (iter_ff == CW'(CORDIC_STEPS - 1));
      sts.out_free = !valid_ff || rsp_tready;
   end

   // start angle reduced to [0, 360)
   logic signed [18:0] sa0, sa1, sa2, sa3;
   logic [AW-1:0]      angle_init;
   always_comb begin
      sa0 = signed'({start_ff[17], start_ff});
      sa1 = (sa0 < 0) ? sa0 + DEG360_Q8 : sa0;
      sa2 = (sa1 < 0) ? sa1 + DEG360_Q8 : sa1;
      sa3 = (sa2 >= DEG360_Q8) ? sa2 - DEG360_Q8 : sa2;
      angle_init = AW'(sa3[16:0]) << (ANGLE_FRAC_BITS - 8);
   end

   // divider step
   logic [16:0] dtrial;
   logic        dge;
   logic [15:0] rem_n;
   logic [9:0]  qhi_t;
   logic [8:0]  qhi_n;
   logic [ANGLE_FRAC_BITS-1:0] qlo_n;
   always_comb begin
      dtrial = {rem_ff, dvd_ff[15]};
      dge    = (dtrial >= {1'b0, beams_ff});
      rem_n  = dge ? 16'(dtrial - {1'b0, beams_ff}) : dtrial[15:0];
      qhi_t  = {qhi_ff, dge};
      qhi_n  = qhi_ff;
      qlo_n  = qlo_ff;
      if (iter_ff < CW'(16)) begin
         qhi_n = (qhi_t >= {1'b0, DEG360}) ? 9'(qhi_t - {1'b0, DEG360}) : qhi_t[8:0];
      end else begin
         qlo_n = {qlo_ff[ANGLE_FRAC_BITS-2:0], dge};
      end
   end

   // rotation start
   logic [63:0]          prod;
   logic signed [ZW-1:0] za, zb, zc;
   logic                 flip_n;
   always_comb begin
      prod   = 64'(mag_ff) * 64'(INV_GAIN_Q32);
      za     = ZW'(angle_ff) <<< (30 - ANGLE_FRAC_BITS);
      zb     = (za > DEG180_Q30) ? za - DEG360_Q30 : za;
      zc     = zb;
      flip_n = 1'b0;
      if (zb > DEG90_Q30) begin
         zc     = zb - DEG180_Q30;
         flip_n = 1'b1;
      end else if (zb < -DEG90_Q30) begin
         zc     = zb + DEG180_Q30;
         flip_n = 1'b1;
      end
   end

   // CORDIC step
   logic signed [XW-1:0] dx, dy;
   logic signed [ZW-1:0] at;
   always_comb begin
      dx = y_ff >>> iter_ff[4:0];
      dy = x_ff >>> iter_ff[4:0];
      at = atan_q30(iter_ff[4:0]);
   end

   // final rounding
   logic signed [XW-1:0] xf, yf, xr, yr;
   logic [AW:0]          angle_sum;
   always_comb begin
      xf = flip_ff ? -x_ff : x_ff;
      yf = flip_ff ? -y_ff : y_ff;
      xr = (xf + XW'(128)) >>> 8;
      yr = (yf + XW'(128)) >>> 8;
      angle_sum = {1'b0, angle_ff} + {1'b0, step_ff};
   end

   // control and header state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         offset_ff <= '0;
         beams_ff  <= '0;
         sector_ff <= '0;
         res_ff    <= '0;
         lat_ff    <= '0;
         hold_ff   <= '0;
         done_ff   <= '0;
         angle_ff  <= '0;
         step_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            start_ff <= csr_data;
         end
         if (cmd.accept) begin
            offset_ff <= (cur < OFFSET_MAX) ? cur + 18'd1 : cur;
            unique case (cur)
               OFS_BEAMS_HI: beams_ff[15:8]  <= data_byte;
               OFS_BEAMS_LO: beams_ff[7:0]   <= data_byte;
               OFS_SECT_HI:  sector_ff[15:8] <= data_byte;
               OFS_SECT_LO:  sector_ff[7:0]  <= data_byte;
               OFS_RES_HI:   res_ff[15:8]    <= data_byte;
               OFS_RES_LO:   res_ff[7:0]     <= data_byte;
               OFS_LAT_HI:   lat_ff[15:8]    <= data_byte;
               OFS_LAT_LO:   lat_ff[7:0]     <= data_byte;
               default: ;
            endcase
            if (at_data && !odd_rel) begin
               hold_ff <= data_byte;
            end
            if (sts.is_bdo) begin
               angle_ff <= angle_init;
               done_ff  <= '0;
            end
         end
         if (cmd.div_step && sts.div_last) begin
            step_ff <= (beams_ff != 16'd0) ? {qhi_n, qlo_n} : '0;
         end
         if (cmd.fin) begin
            done_ff  <= done_ff + 16'd1;
            angle_ff <= (angle_sum >= (AW+1)'(360) << ANGLE_FRAC_BITS)
                        ? AW'(angle_sum - ((AW+1)'(360) << ANGLE_FRAC_BITS))
                        : angle_sum[AW-1:0];
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         range_ff <= {hold_ff, data_byte};
         rem_ff   <= '0;
         dvd_ff   <= sector_ff;
         qhi_ff   <= '0;
         qlo_ff   <= '0;
         iter_ff  <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_n;
         dvd_ff  <= {dvd_ff[14:0], 1'b0};
         qhi_ff  <= qhi_n;
         qlo_ff  <= qlo_n;
         iter_ff <= iter_ff + CW'(1);
      end
      if (cmd.mul1) begin
         mag_ff <= 32'(range_ff) * 32'(res_ff);
      end
      if (cmd.mul2) begin
         x_ff    <= XW'(prod[63:16]);
         y_ff    <= '0;
         z_ff    <= zc;
         flip_ff <= flip_n;
         iter_ff <= '0;
      end
      if (cmd.rot_step) begin
         if (!z_ff[ZW-1]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at;
         end
         iter_ff <= iter_ff + CW'(1);
      end
      if (cmd.fin) begin
         xo_ff   <= sat_out(xr);
         yo_ff   <= sat_out(yr);
         idx_ff  <= done_ff;
         lato_ff <= lat_ff;
         last_ff <= ({1'b0, done_ff} + 17'd1) == {1'b0, beams_ff};
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign x_pos        = xo_ff;
   assign y_pos        = yo_ff;
   assign beam_index   = idx_ff;
   assign ping_latency = lato_ff;
   assign last_beam    = last_ff;

endmodule

`default_nettype wire

[rtl/sonar_packet_to_xy_points.sv]
// ----------------------------------------------------------------------------
// Sonar packet to x/y points - top level
// Parses sonar ping bytes and emits one CORDIC-rotated x/y point per beam.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/tready      tdata: data_byte; tuser: packet_start
// rsp_      out  rsp_tvalid/tready      tdata: x,y,index,latency; tlast: last
// csr_      in   csr_valid/csr_ready    csr_data: start_angle
//
// Header bytes, high range bytes and bytes past the last beam are accepted
// directly; the byte at the beam data offset runs the restoring divider, and
// the low byte of a beam runs two multiplies, 24 CORDIC iterations and
// rounding, before the next byte is accepted. Results wait in an output
// register; a further beam stalls only while that register is full. Reset is
// synchronous and clears the parser, angle state and result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sonar_packet_to_xy_points #(
   parameter int ANGLE_FRAC_BITS  = 16,
   parameter int BEAM_DATA_OFFSET = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tuser,   // [0] packet_start
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [119:0]      rsp_tdata,   // x_pos, y_pos, beam_index, ping_latency, pad
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [17:0]  csr_data
);
   import spxy_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [OUT_W-1:0] x_pos, y_pos;
   logic [15:0]      beam_index, ping_latency;

   assign csr_ready = 1'b1;

   spxy_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   spxy_datapath #(
      .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
      .BEAM_DATA_OFFSET (BEAM_DATA_OFFSET)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .data_byte    (req_tdata),
      .packet_start (req_tuser),
      .csr_we       (csr_valid),
      .csr_data     (csr_data),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .x_pos        (x_pos),
      .y_pos        (y_pos),
      .beam_index   (beam_index),
      .ping_latency (ping_latency),
      .last_beam    (rsp_tlast),
      .cmd          (cmd),
      .sts          (sts)
   );

   assign rsp_tdata = {6'd0, ping_latency, beam_index, y_pos, x_pos};

endmodule

`default_nettype wire

[rtl/spxy_checker.sv]
// ----------------------------------------------------------------------------
// Sonar packet to x/y points - port checker
// Temporal checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sonar_packet_to_xy_points_defines.svh"

module spxy_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready
);

   `SPXY_ASSERT_ALWAYS(a_rst_clears, clock, reset |=> !rsp_tvalid, "result valid after reset")
   `SPXY_ASSERT(a_hold_valid, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped")
   `SPXY_ASSERT(a_rise_busy, clock, reset, $rose(rsp_tvalid) |-> $past(!req_tready), "result not from busy phase")

endmodule

bind sonar_packet_to_xy_points spxy_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
